// ----- design/pmed_pkg.sv -----
// ----------------------------------------------------------------------------
// pmed_pkg
// shared types and constants for the manhattan p-median search unit
// ----------------------------------------------------------------------------
package pmed_pkg;

  // default sizes handed to the top level parameters
  localparam int MAX_SITES_DEF   = 16;
  localparam int MAX_DEMANDS_DEF = 128;
  localparam int MAX_SIDE_DEF    = 64;

  // fixed field widths
  localparam int GRID_SIDE_W  = 7;
  localparam int OPEN_COUNT_W = 5;
  localparam int CELL_KIND_W  = 2;
  localparam int TOTAL_W      = 14;
  localparam int STATUS_W     = 2;
  localparam int CFG_DATA_W   = 7;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 14'h3fff;

  // cell content codes
  typedef enum logic [CELL_KIND_W-1:0] {
    KIND_EMPTY  = 2'd0,
    KIND_DEMAND = 2'd1,
    KIND_SITE   = 2'd2
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FLAG    = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_GRID_SIDE  = 1'b0,
    REG_OPEN_COUNT = 1'b1
  } reg_idx_t;

endpackage

// ----- design/pmed_front.sv -----
// ----------------------------------------------------------------------------
// pmed_front
// accepts cells, tracks the raster position and classifies each cell
// ----------------------------------------------------------------------------
module pmed_front import pmed_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  localparam int POS_W   = $clog2(MAX_SIDE),
  localparam int ENTRY_W = 2 * POS_W + CELL_KIND_W + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [GRID_SIDE_W-1:0] grid_side,
  input  logic                   cell_valid,
  input  logic [CELL_KIND_W-1:0] cell_kind,
  output logic                   cell_ready,
  output logic                   push,
  output logic [ENTRY_W-1:0]     push_data,
  input  logic                   queue_full
);

  localparam int CW = (POS_W + 1 > GRID_SIDE_W) ? POS_W + 1 : GRID_SIDE_W;

  logic [POS_W-1:0] row_r, row_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  logic [CW-1:0]    gs_ext, side_c, col_inc, row_inc;
  logic             end_col, end_row, last;
  kind_t            kind;

  assign cell_ready = !queue_full;
  assign push       = cell_valid && !queue_full;

  // clamp the side length into its legal range
  always_comb begin
    gs_ext = CW'(grid_side);
    if (gs_ext == '0) begin
      side_c = CW'(1);
    end else if (gs_ext > CW'(MAX_SIDE)) begin
      side_c = CW'(MAX_SIDE);
    end else begin
      side_c = gs_ext;
    end
  end

  // classify the cell, unknown codes count as empty
  always_comb begin
    case (cell_kind)
      KIND_DEMAND: kind = KIND_DEMAND;
      KIND_SITE:   kind = KIND_SITE;
      default:     kind = KIND_EMPTY;
    endcase
  end

  // raster position step
  always_comb begin
    col_inc = CW'(col_r) + CW'(1);
    row_inc = CW'(row_r) + CW'(1);
    end_col = col_inc >= side_c;
    end_row = row_inc >= side_c;
    last    = end_col && end_row;
    row_nxt = row_r;
    col_nxt = col_r;
    if (end_col) begin
      col_nxt = '0;
      row_nxt = end_row ? '0 : row_inc[POS_W-1:0];
    end else begin
      col_nxt = col_inc[POS_W-1:0];
    end
  end

  assign push_data = {last, kind, row_r, col_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (push) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// ----- design/pmed_queue.sv -----
// ----------------------------------------------------------------------------
// pmed_queue
// short fifo between the cell front end and the search engine
// ----------------------------------------------------------------------------
module pmed_queue import pmed_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r, rd_r;
  logic [AW:0]      cnt_r;
  logic             do_push, do_pop;

  assign full     = cnt_r == (AW + 1)'(DEPTH);
  assign avail    = cnt_r != '0;
  assign pop_data = mem_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + AW'(1);
      if (do_pop)  rd_r <= rd_r + AW'(1);
      cnt_r <= cnt_r + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
    end
  end

endmodule

// ----- design/pmed_back.sv -----
// ----------------------------------------------------------------------------
// pmed_back
// stores demand points and sites, runs the exhaustive subset search
// ----------------------------------------------------------------------------
module pmed_back import pmed_pkg::*; #(
  parameter int MAX_SITES   = MAX_SITES_DEF,
  parameter int MAX_DEMANDS = MAX_DEMANDS_DEF,
  parameter int MAX_SIDE    = MAX_SIDE_DEF,
  localparam int POS_W      = $clog2(MAX_SIDE),
  localparam int ENTRY_W    = 2 * POS_W + CELL_KIND_W + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [OPEN_COUNT_W-1:0] open_count,
  input  logic                    avail,
  input  logic [ENTRY_W-1:0]      pop_data,
  output logic                    pop,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [TOTAL_W-1:0]      res_total,
  output logic [STATUS_W-1:0]     res_status
);

  localparam int ST_W   = $clog2(MAX_SITES + 1);
  localparam int SI_W   = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int DT_W   = $clog2(MAX_DEMANDS + 1);
  localparam int DA_W   = (MAX_DEMANDS > 1) ? $clog2(MAX_DEMANDS) : 1;
  localparam int MW     = MAX_SITES + 1;
  localparam int DIST_W = POS_W + 1;
  localparam int SUM_W  = DT_W + DIST_W;
  localparam int CMP_W  = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
  localparam int OC_W   = (ST_W > OPEN_COUNT_W) ? ST_W : OPEN_COUNT_W;
  localparam int PC_W   = $clog2(MAX_SITES + 1) + 1;

  typedef enum logic [2:0] {
    ST_LOAD, ST_START, ST_MASK, ST_DREAD, ST_SITE, ST_OUT
  } state_t;

  state_t state_r;

  // entry fields
  logic             e_last;
  kind_t            e_kind;
  logic [POS_W-1:0] e_row, e_col;
  assign {e_last, e_kind, e_row, e_col} = pop_data;
  assign pop = avail && (state_r == ST_LOAD);

  // stores
  logic [POS_W-1:0] site_row_r [MAX_SITES];
  logic [POS_W-1:0] site_col_r [MAX_SITES];
  logic [2*POS_W-1:0] dem_mem [MAX_DEMANDS];
  logic [2*POS_W-1:0] dem_q_r;
  logic [ST_W-1:0]  site_total_r;
  logic [DT_W-1:0]  demand_total_r;
  logic             ovf_r;

  // search registers
  logic [MW-1:0]     mask_r;
  logic [DT_W-1:0]   d_r;
  logic [SI_W-1:0]   s_r;
  logic [DIST_W-1:0] near_r;
  logic              near_ok_r;
  logic [SUM_W-1:0]  sum_r, best_r;
  logic [TOTAL_W-1:0]  fin_total_r;
  status_t             fin_status_r;

  // output register
  logic                out_valid_r;
  logic [TOTAL_W-1:0]  out_total_r;
  status_t             out_status_r;
  logic                out_load;

  assign res_valid  = out_valid_r;
  assign res_total  = out_total_r;
  assign res_status = out_status_r;
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || res_ready);

  function automatic logic [PC_W-1:0] popcnt(input logic [MAX_SITES-1:0] v);
    logic [PC_W-1:0] c;
    c = '0;
    for (int i = 0; i < MAX_SITES; i++) begin
      c = c + PC_W'(v[i]);
    end
    return c;
  endfunction

  // distance from the held demand point to site s
  logic [POS_W-1:0]  d_row, d_col, s_row, s_col, dr, dc;
  logic [DIST_W-1:0] span, near_fin;
  logic              take, mask_hit, last_site, last_dem;
  logic [MW-1:0]     limit;
  logic [SUM_W-1:0]  cost;

  always_comb begin
    {d_row, d_col} = dem_q_r;
    s_row    = site_row_r[s_r];
    s_col    = site_col_r[s_r];
    dr       = (d_row > s_row) ? d_row - s_row : s_row - d_row;
    dc       = (d_col > s_col) ? d_col - s_col : s_col - d_col;
    span     = DIST_W'(dr) + DIST_W'(dc);
    take     = mask_r[s_r] && (!near_ok_r || span < near_r);
    near_fin = take ? span : near_r;
    last_site = ST_W'(s_r) + ST_W'(1) == site_total_r;
    last_dem  = d_r + DT_W'(1) == demand_total_r;
    cost     = sum_r + SUM_W'(near_fin);
    limit    = MW'(1) << site_total_r;
    mask_hit = OC_W'(popcnt(mask_r[MAX_SITES-1:0])) == OC_W'(open_count);
  end

  // demand memory
  always_ff @(posedge clk) begin
    if (pop && e_kind == KIND_DEMAND && demand_total_r < DT_W'(MAX_DEMANDS)) begin
      dem_mem[demand_total_r[DA_W-1:0]] <= {e_row, e_col};
    end
    if (state_r == ST_DREAD) begin
      dem_q_r <= dem_mem[d_r[DA_W-1:0]];
    end
  end

  // site store
  always_ff @(posedge clk) begin
    if (pop && e_kind == KIND_SITE && site_total_r < ST_W'(MAX_SITES)) begin
      site_row_r[site_total_r[SI_W-1:0]] <= e_row;
      site_col_r[site_total_r[SI_W-1:0]] <= e_col;
    end
  end

  // result register toward the receiver
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r  <= 1'b1;
      out_total_r  <= fin_total_r;
      out_status_r <= fin_status_r;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_LOAD;
      site_total_r   <= '0;
      demand_total_r <= '0;
      ovf_r          <= 1'b0;
    end else begin
      case (state_r)
        // store incoming cells
        ST_LOAD: begin
          if (pop) begin
            if (e_kind == KIND_SITE) begin
              if (site_total_r < ST_W'(MAX_SITES)) site_total_r <= site_total_r + ST_W'(1);
              else ovf_r <= 1'b1;
            end else if (e_kind == KIND_DEMAND) begin
              if (demand_total_r < DT_W'(MAX_DEMANDS)) begin
                demand_total_r <= demand_total_r + DT_W'(1);
              end else begin
                ovf_r <= 1'b1;
              end
            end
            if (e_last) state_r <= ST_START;
          end
        end
        // check the open count and set up the search
        ST_START: begin
          mask_r <= '0;
          best_r <= '1;
          if (open_count == '0 || OC_W'(open_count) > OC_W'(site_total_r)) begin
            fin_total_r  <= '0;
            fin_status_r <= STAT_INVALID;
            state_r      <= ST_OUT;
          end else begin
            state_r <= ST_MASK;
          end
        end
        // walk the subset masks
        ST_MASK: begin
          if (mask_r == limit) begin
            if (CMP_W'(best_r) > CMP_W'(TOTAL_MAX)) begin
              fin_total_r  <= TOTAL_MAX;
              fin_status_r <= STAT_FLAG;
            end else begin
              fin_total_r  <= TOTAL_W'(best_r);
              fin_status_r <= ovf_r ? STAT_FLAG : STAT_OK;
            end
            state_r <= ST_OUT;
          end else if (mask_hit && demand_total_r != '0) begin
            d_r     <= '0;
            sum_r   <= '0;
            state_r <= ST_DREAD;
          end else begin
            if (mask_hit) best_r <= '0;
            mask_r <= mask_r + MW'(1);
          end
        end
        // fetch one demand point
        ST_DREAD: begin
          s_r       <= '0;
          near_ok_r <= 1'b0;
          state_r   <= ST_SITE;
        end
        // nearest chosen site, one site per cycle
        ST_SITE: begin
          near_r <= near_fin;
          if (take) near_ok_r <= 1'b1;
          s_r <= s_r + SI_W'(1);
          if (last_site) begin
            sum_r <= cost;
            d_r   <= d_r + DT_W'(1);
            if (last_dem) begin
              if (cost < best_r) best_r <= cost;
              mask_r  <= mask_r + MW'(1);
              state_r <= ST_MASK;
            end else begin
              state_r <= ST_DREAD;
            end
          end
        end
        // hand the result to the output register and clear the grid
        ST_OUT: begin
          if (out_load) begin
            site_total_r   <= '0;
            demand_total_r <= '0;
            ovf_r          <= 1'b0;
            state_r        <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  // checks
  a_site_bound: assert property (@(posedge clk) disable iff (!rst_n)
    site_total_r <= ST_W'(MAX_SITES))
    else $error("site total beyond store depth");

  a_site_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SITE |-> ST_W'(s_r) < site_total_r)
    else $error("site index past stored sites");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == STAT_INVALID |-> out_total_r == '0)
    else $error("invalid status with nonzero total");

  a_mask_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SITE |-> mask_r < limit)
    else $error("mask beyond subset range");

endmodule

// ----- design/manhattan_p_median_search_unit.sv -----
// ----------------------------------------------------------------------------
// manhattan_p_median_search_unit
// exhaustive manhattan p-median search over a square grid of cells
// ----------------------------------------------------------------------------
// Cells arrive in raster order on the in_ stream, one cell per transfer, kind
// in in_tdata. A four-entry queue sits between the cell front end and the
// search engine, so cells load at one per cycle while the engine is storing.
// The last cell of a grid starts the search: the engine walks every mask
// below 2^sites, and for each mask with the open count reads each demand
// point through the one registered read port of the demand memory, then
// one shared distance unit visits one site per cycle. After the search one
// result transfer carries best_total and status. The result sits in an
// output register; while the receiver stalls it, the engine already stores
// cells of the next grid. The user must make config writes (cfg_ready is
// always high) only while the block is idle; it is not enforced. Reset
// clears position, totals and flags; grid_side and open_count return to 1.
// ----------------------------------------------------------------------------
module manhattan_p_median_search_unit import pmed_pkg::*; #(
  parameter int MAX_SITES   = MAX_SITES_DEF,
  parameter int MAX_DEMANDS = MAX_DEMANDS_DEF,
  parameter int MAX_SIDE    = MAX_SIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [1:0] cell_kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [13:0] best_total, [15:14] status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  reg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int POS_W   = $clog2(MAX_SIDE);
  localparam int ENTRY_W = 2 * POS_W + CELL_KIND_W + 1;

  logic [GRID_SIDE_W-1:0]  grid_side_r;
  logic [OPEN_COUNT_W-1:0] open_count_r;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r  <= GRID_SIDE_W'(1);
      open_count_r <= OPEN_COUNT_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_SIDE:  grid_side_r  <= cfg_data[GRID_SIDE_W-1:0];
        REG_OPEN_COUNT: open_count_r <= cfg_data[OPEN_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic               push, full, avail, pop;
  logic [ENTRY_W-1:0] push_data, pop_data;
  logic [TOTAL_W-1:0]  res_total;
  logic [STATUS_W-1:0] res_status;

  pmed_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .grid_side  (grid_side_r),
    .cell_valid (in_tvalid),
    .cell_kind  (in_tdata[CELL_KIND_W-1:0]),
    .cell_ready (in_tready),
    .push       (push),
    .push_data  (push_data),
    .queue_full (full)
  );

  pmed_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_data)
  );

  pmed_back #(
    .MAX_SITES   (MAX_SITES),
    .MAX_DEMANDS (MAX_DEMANDS),
    .MAX_SIDE    (MAX_SIDE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .open_count (open_count_r),
    .avail      (avail),
    .pop_data   (pop_data),
    .pop        (pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_total  (res_total),
    .res_status (res_status)
  );

  assign out_tdata = {res_status, res_total};

endmodule

// ----- tb/manhattan_p_median_search_unit_chk.sv -----
// ----------------------------------------------------------------------------
// manhattan_p_median_search_unit_chk
// scoreboard for the p-median search unit: tracks register writes and grid
// cells, works out the minimum nearest-site distance sum of each finished
// grid and compares it with every result transfer
// ----------------------------------------------------------------------------
module manhattan_p_median_search_unit_chk import pmed_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [1:0] cell_kind
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [15:0]           out_tdata,  // [13:0] best_total, [15:14] status
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  reg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    status_t            status;
  } grid_result_t;

  grid_result_t result_q[$];

  // shadow copy of the block state
  logic [GRID_SIDE_W-1:0]  side_reg;
  logic [OPEN_COUNT_W-1:0] open_reg;
  logic [5:0] site_row [MAX_SITES_DEF];
  logic [5:0] site_col [MAX_SITES_DEF];
  logic [5:0] dem_row  [MAX_DEMANDS_DEF];
  logic [5:0] dem_col  [MAX_DEMANDS_DEF];
  int unsigned site_cnt, dem_cnt, row_pos, col_pos;
  bit overflow;

  assign pending = result_q.size();

  // exhaustive search over all subsets with the open count
  function automatic grid_result_t best_placement();
    grid_result_t r;
    int unsigned best, cost, near, span;
    if (open_reg == 0 || open_reg > site_cnt) begin
      r.total  = '0;
      r.status = STAT_INVALID;
      return r;
    end
    best = 32'hffff_ffff;
    for (int unsigned mask = 0; mask < (32'd1 << site_cnt); mask++) begin
      if ($countones(mask) != open_reg) continue;
      cost = 0;
      for (int d = 0; d < dem_cnt; d++) begin
        near = 32'hffff_ffff;
        for (int s = 0; s < site_cnt; s++) begin
          if (!mask[s]) continue;
          span = (dem_row[d] > site_row[s] ? dem_row[d] - site_row[s]
                                           : site_row[s] - dem_row[d])
               + (dem_col[d] > site_col[s] ? dem_col[d] - site_col[s]
                                           : site_col[s] - dem_col[d]);
          if (span < near) near = span;
        end
        cost += near;
      end
      if (cost < best) best = cost;
    end
    r.status = STAT_OK;
    if (best > TOTAL_MAX) begin
      best     = TOTAL_MAX;
      r.status = STAT_FLAG;
    end
    if (overflow) r.status = STAT_FLAG;
    r.total = best[TOTAL_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    int unsigned side;
    grid_result_t exp_r;
    if (!rst_n) begin
      side_reg   <= 7'd1;
      open_reg   <= 5'd1;
      site_cnt   = 0;
      dem_cnt    = 0;
      row_pos    = 0;
      col_pos    = 0;
      overflow   = 0;
      fail_count <= 0;
      result_q.delete();
    end else begin
      // register write transfer
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRID_SIDE) side_reg <= cfg_data[GRID_SIDE_W-1:0];
        else                            open_reg <= cfg_data[OPEN_COUNT_W-1:0];
      end
      // cell transfer
      if (in_tvalid && in_tready) begin
        side = (side_reg == 0) ? 1 : (side_reg > MAX_SIDE_DEF) ? MAX_SIDE_DEF : side_reg;
        if (in_tdata[1:0] == KIND_SITE) begin
          if (site_cnt < MAX_SITES_DEF) begin
            site_row[site_cnt] = row_pos[5:0];
            site_col[site_cnt] = col_pos[5:0];
            site_cnt++;
          end else overflow = 1;
        end else if (in_tdata[1:0] == KIND_DEMAND) begin
          if (dem_cnt < MAX_DEMANDS_DEF) begin
            dem_row[dem_cnt] = row_pos[5:0];
            dem_col[dem_cnt] = col_pos[5:0];
            dem_cnt++;
          end else overflow = 1;
        end
        if (col_pos + 1 >= side) begin
          col_pos = 0;
          if (row_pos + 1 >= side) begin
            result_q.insert(result_q.size(), best_placement());
            site_cnt = 0;
            dem_cnt  = 0;
            row_pos  = 0;
            overflow = 0;
          end else row_pos++;
        end else col_pos++;
      end
      // result transfer
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result total=%0d status=%0d", $time,
                   out_tdata[13:0], out_tdata[15:14]);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (out_tdata[13:0] !== exp_r.total || out_tdata[15:14] !== exp_r.status) begin
            $display("%0t: mismatch expected total=%0d status=%0d, got total=%0d status=%0d",
                     $time, exp_r.total, exp_r.status, out_tdata[13:0], out_tdata[15:14]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/manhattan_p_median_search_unit_tb.sv -----
// ----------------------------------------------------------------------------
// manhattan_p_median_search_unit_tb
// drives grids of cells and register settings into the search unit, with
// random gaps on both streams; a scoreboard module checks every result
// ----------------------------------------------------------------------------
module manhattan_p_median_search_unit_tb import pmed_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [1:0] cell_kind
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;  // [13:0] best_total, [15:14] status
  logic                  cfg_valid;
  logic                  cfg_ready;
  reg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  int send_idle;
  int recv_idle;
  bit hold_req;

  manhattan_p_median_search_unit dut (.*);

  manhattan_p_median_search_unit_chk chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int hold_cnt;
    bit held;
    hold_cnt   = 0;
    held       = 0;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        hold_cnt = 400;
        held     = 1;
      end
      if (hold_cnt > 0) begin
        out_tready <= 0;
        hold_cnt--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // one cell transfer, called and returning at a falling edge
  task automatic send_cell(input logic [1:0] kind);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {6'b0, kind};
    #1;
    while (!in_tready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
  endtask

  // register write once nothing is outstanding and the engine has drained
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    #1;
    while (!cfg_ready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_grid(input int side, input int site_cap);
    int sites;
    logic [1:0] k;
    sites = 0;
    for (int i = 0; i < side * side; i++) begin
      k = 2'($urandom_range(0, 3));
      if (k == KIND_SITE) begin
        if (sites >= site_cap) k = KIND_DEMAND;
        else sites++;
      end
      send_cell(k);
    end
  endtask

  initial begin
    int side;
    rst_n     = 0;
    in_tvalid = 0;
    in_tdata  = '0;
    cfg_valid = 0;
    cfg_index = REG_GRID_SIDE;
    cfg_data  = '0;
    send_idle = 0;
    recv_idle = 0;
    hold_req  = 0;
    repeat (3) @(negedge clk);
    rst_n = 1;

    // one-cell grids at the reset setting, including the unknown kind
    send_cell(KIND_EMPTY);
    send_cell(KIND_SITE);
    send_cell(KIND_DEMAND);
    send_cell(2'd3);
    // side zero acts as one
    write_reg(REG_GRID_SIDE, 7'd0);
    send_cell(KIND_SITE);
    // two by two grids over several open counts
    write_reg(REG_GRID_SIDE, 7'd2);
    send_cell(KIND_DEMAND); send_cell(KIND_SITE);
    send_cell(2'd3);        send_cell(KIND_DEMAND);
    for (int oc = 0; oc <= 3; oc++) begin
      write_reg(REG_OPEN_COUNT, oc[4:0]);
      send_cell(KIND_SITE);   send_cell(KIND_DEMAND);
      send_cell(KIND_DEMAND); send_cell(KIND_SITE);
    end
    // oversized side, then shrunk mid-grid so the grid ends early
    write_reg(REG_OPEN_COUNT, 5'd1);
    write_reg(REG_GRID_SIDE, 7'd127);
    send_cell(KIND_SITE);
    for (int i = 0; i < 69; i++) send_cell(2'($urandom_range(0, 1)));
    write_reg(REG_GRID_SIDE, 7'd2);
    send_cell(KIND_DEMAND);
    // site store overflow with the largest open counts
    write_reg(REG_GRID_SIDE, 7'd5);
    for (int oc = 16; oc >= 15; oc--) begin
      write_reg(REG_OPEN_COUNT, oc[4:0]);
      for (int i = 0; i < 17; i++) send_cell(KIND_SITE);
      for (int i = 0; i < 8; i++) send_cell(i < 2 ? KIND_DEMAND : KIND_EMPTY);
    end
    // demand store overflow
    write_reg(REG_OPEN_COUNT, 5'd1);
    write_reg(REG_GRID_SIDE, 7'd12);
    send_cell(KIND_SITE);
    for (int i = 0; i < 143; i++) send_cell(KIND_DEMAND);

    // random grids in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 11 : (ph == 1) ? 67 : 0;
      recv_idle = (ph == 0) ? 67 : (ph == 1) ? 11 : 0;
      for (int b = 0; b < 6; b++) begin
        // small grids during the long hold-off so results pile up
        side = (ph == 2 && b == 2) ? 2 : $urandom_range(1, 7);
        write_reg(REG_GRID_SIDE, side[6:0]);
        write_reg(REG_OPEN_COUNT, 5'($urandom_range(0, 6)));
        if (ph == 2 && b == 2) hold_req = 1;
        for (int g = 0; g < 500 / (side * side * 6) + 1; g++) send_grid(side, 5);
      end
    end
    in_tvalid <= 0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
design/pmed_pkg.sv
design/pmed_front.sv
design/pmed_queue.sv
design/pmed_back.sv
design/manhattan_p_median_search_unit.sv
tb/manhattan_p_median_search_unit_chk.sv
tb/manhattan_p_median_search_unit_tb.sv
